// File: src/rgba8_texture_tiler_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RGBA8 texture tiler
// Short forms for the clocked, reset-qualified properties used in the RTL.
// ----------------------------------------------------------------------------
`ifndef RGBA8_TEXTURE_TILER_UNIT_MACROS_SVH
`define RGBA8_TEXTURE_TILER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define RGBA8TT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgba8tt: same-cycle check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define RGBA8TT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgba8tt: next-cycle check failed");

`endif

// File: src/rgba8tt_pkg.sv
// ----------------------------------------------------------------------------
// RGBA8 texture tiler package
// Shared types, constants and word-packing functions.
// ----------------------------------------------------------------------------
package rgba8tt_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd480;

    localparam int PIX_W   = 32;
    localparam int ROW_PIX = 4;
    localparam int ROW_W   = PIX_W * ROW_PIX;
    localparam int WORD_W  = 64;
    localparam int WIDX_W  = 3;
    localparam logic [WIDX_W-1:0] WORD_LAST = 3'd7;

    localparam int QDEPTH = 2;

    typedef logic [PIX_W-1:0]           t_pix;
    typedef logic [ROW_W-1:0]           t_row;
    typedef logic [0:ROW_PIX-1][ROW_W-1:0] t_tile;
    typedef logic [WORD_W-1:0]          t_word;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_status;

    // Pixels are packed R,G,B,A from the top byte down; the first pixel of a
    // tile row sits in the top 32 bits of the row.
    function automatic t_word ar_word(input t_row row);
        t_word w;
        t_pix  p;
        for (int i = 0; i < ROW_PIX; i++) begin
            p = row[ROW_W-1-PIX_W*i -: PIX_W];
            w[WORD_W-1-16*i -: 16] = {p[7:0], p[31:24]};
        end
        return w;
    endfunction

    function automatic t_word gb_word(input t_row row);
        t_word w;
        t_pix  p;
        for (int i = 0; i < ROW_PIX; i++) begin
            p = row[ROW_W-1-PIX_W*i -: PIX_W];
            w[WORD_W-1-16*i -: 16] = p[23:8];
        end
        return w;
    endfunction

endpackage

// File: src/rgba8tt_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rgba8tt_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/rgba8tt_front.sv
// ----------------------------------------------------------------------------
// RGBA8 texture tiler front end
// Holds the geometry registers, tracks the raster position, fills the line
// store and gathers each finished tile into one queue entry.
// ----------------------------------------------------------------------------
module rgba8tt_front #(
    parameter int MAX_WIDTH  = rgba8tt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rgba8tt_pkg::MAX_HEIGHT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic [7:0]                         i_red,
    input  logic [7:0]                         i_green,
    input  logic [7:0]                         i_blue,
    input  logic [7:0]                         i_alpha,
    input  logic                               i_cfg_we,
    input  logic [rgba8tt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rgba8tt_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                               i_q_full,
    output logic                               o_ram_we,
    output logic [$clog2(3*(MAX_WIDTH/4))-1:0] o_ram_waddr,
    output rgba8tt_pkg::t_row                  o_ram_wdata,
    output logic                               o_ram_re,
    output logic [$clog2(3*(MAX_WIDTH/4))-1:0] o_ram_raddr,
    input  rgba8tt_pkg::t_row                  i_ram_rdata,
    output logic                               o_push,
    output rgba8tt_pkg::t_tile                 o_push_tile
);
    import rgba8tt_pkg::*;

    localparam int GROUPS = MAX_WIDTH / 4;
    localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int BANDS  = MAX_HEIGHT / 4;
    localparam int BW     = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int AW     = $clog2(3 * GROUPS);
    localparam int CW     = CFG_W + 2;

    logic [CFG_W-1:0] r_width,   n_width;
    logic [CFG_W-1:0] r_height,  n_height;
    logic [GW-1:0]    r_grp,     n_grp;
    logic [BW-1:0]    r_band,    n_band;
    logic [1:0]       r_sub,     n_sub;
    logic [1:0]       r_sub_row, n_sub_row;
    logic             r_rd_pend;
    logic [1:0]       r_rd_sel;
    t_pix             r_seg  [0:2];
    t_row             r_rows [0:2];

    logic geom_ok;
    logic last_grp;
    logic last_band;
    logic take;
    logic row3;
    logic sub3;
    t_pix pix;
    t_row seg_row;

    function automatic logic [AW-1:0] store_addr(input logic [1:0] row,
                                                 input logic [GW-1:0] grp);
        logic [AW-1:0] a;
        a = AW'(grp);
        if (row == 2'd1) begin
            a = a + AW'(GROUPS);
        end else if (row == 2'd2) begin
            a = a + AW'(2 * GROUPS);
        end
        return a;
    endfunction

    assign geom_ok = (r_width != '0) && (r_height != '0)
                  && (r_width[1:0] == 2'b00) && (r_height[1:0] == 2'b00)
                  && (32'(r_width) <= 32'(MAX_WIDTH))
                  && (32'(r_height) <= 32'(MAX_HEIGHT));

    assign last_grp  = (CW'(r_grp) + CW'(1)) == CW'(r_width[CFG_W-1:2]);
    assign last_band = (CW'(r_band) + CW'(1)) == CW'(r_height[CFG_W-1:2]);

    assign take    = i_in_valid && !i_q_full && geom_ok;
    assign row3    = (r_sub_row == 2'd3);
    assign sub3    = (r_sub == 2'd3);
    assign pix     = {i_red, i_green, i_blue, i_alpha};
    assign seg_row = {r_seg[0], r_seg[1], r_seg[2], pix};

    assign o_ram_we    = take && !row3 && sub3;
    assign o_ram_waddr = store_addr(r_sub_row, r_grp);
    assign o_ram_wdata = seg_row;
    assign o_ram_re    = take && row3 && !sub3;
    assign o_ram_raddr = store_addr(r_sub, r_grp);

    // Row 2 comes straight off the RAM when the last two pixels were back to back.
    assign o_push         = take && row3 && sub3;
    assign o_push_tile[0] = r_rows[0];
    assign o_push_tile[1] = r_rows[1];
    assign o_push_tile[2] = (r_rd_pend && (r_rd_sel == 2'd2)) ? i_ram_rdata : r_rows[2];
    assign o_push_tile[3] = seg_row;

    always_comb begin
        n_width   = r_width;
        n_height  = r_height;
        n_grp     = r_grp;
        n_band    = r_band;
        n_sub     = r_sub;
        n_sub_row = r_sub_row;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IDX_WIDTH: begin
                    n_width   = i_cfg_data;
                    n_grp     = '0;
                    n_band    = '0;
                    n_sub     = '0;
                    n_sub_row = '0;
                end
                CFG_IDX_HEIGHT: begin
                    n_height  = i_cfg_data;
                    n_grp     = '0;
                    n_band    = '0;
                    n_sub     = '0;
                    n_sub_row = '0;
                end
                default: begin
                end
            endcase
        end else if (take) begin
            n_sub = r_sub + 2'd1;
            if (sub3) begin
                if (last_grp) begin
                    n_grp     = '0;
                    n_sub_row = r_sub_row + 2'd1;
                    if (row3) begin
                        n_band = last_band ? '0 : r_band + BW'(1);
                    end
                end else begin
                    n_grp = r_grp + GW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WIDTH_RST;
            r_height  <= HEIGHT_RST;
            r_grp     <= '0;
            r_band    <= '0;
            r_sub     <= '0;
            r_sub_row <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_width   <= n_width;
            r_height  <= n_height;
            r_grp     <= n_grp;
            r_band    <= n_band;
            r_sub     <= n_sub;
            r_sub_row <= n_sub_row;
            r_rd_pend <= o_ram_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ram_re) begin
            r_rd_sel <= r_sub;
        end
        if (r_rd_pend) begin
            r_rows[r_rd_sel] <= i_ram_rdata;
        end
        if (take && !sub3) begin
            r_seg[r_sub] <= pix;
        end
    end

endmodule

// File: src/rgba8tt_queue.sv
// ----------------------------------------------------------------------------
// RGBA8 texture tiler tile queue
// Two-entry queue of gathered tiles between the front and back ends.
// ----------------------------------------------------------------------------
`include "rgba8_texture_tiler_unit_macros.svh"

module rgba8tt_queue #(
    parameter int W = 512
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [W-1:0]           i_data,
    input  logic                   i_pop,
    output logic [W-1:0]           o_data,
    output rgba8tt_pkg::t_q_status o_status
);
    import rgba8tt_pkg::*;

    localparam int PW = $clog2(QDEPTH);
    localparam int NW = $clog2(QDEPTH + 1);

    logic [W-1:0]  r_mem [QDEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [NW-1:0] r_cnt;

    assign o_data             = r_mem[r_rd];
    assign o_status.full      = (r_cnt == NW'(QDEPTH));
    assign o_status.not_empty = (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `RGBA8TT_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, r_cnt != '0)
    `RGBA8TT_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push && !i_pop, r_cnt != NW'(QDEPTH))

endmodule

// File: src/rgba8tt_back.sv
// ----------------------------------------------------------------------------
// RGBA8 texture tiler back end
// Walks the head tile through its eight output words into a held output stage.
// ----------------------------------------------------------------------------
`include "rgba8_texture_tiler_unit_macros.svh"

module rgba8tt_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rgba8tt_pkg::t_q_status         i_q_status,
    input  rgba8tt_pkg::t_tile             i_q_tile,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output rgba8tt_pkg::t_word             o_tile_word,
    output logic [rgba8tt_pkg::WIDX_W-1:0] o_word_index,
    output logic                           o_tile_last
);
    import rgba8tt_pkg::*;

    logic [WIDX_W-1:0] r_widx;
    logic              r_out_valid;
    t_word             r_word;
    logic [WIDX_W-1:0] r_index;
    logic              r_last;

    logic  adv;
    logic  load;
    t_row  row;
    t_word word;

    assign adv   = !r_out_valid || !i_out_stall;
    assign load  = adv && i_q_status.not_empty;
    assign o_pop = load && (r_widx == WORD_LAST);
    assign row   = i_q_tile[r_widx[1:0]];
    assign word  = r_widx[2] ? gb_word(row) : ar_word(row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx      <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= i_q_status.not_empty;
            if (load) begin
                r_widx <= r_widx + WIDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word  <= word;
            r_index <= r_widx;
            r_last  <= (r_widx == WORD_LAST);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_tile_word  = r_word;
    assign o_word_index = r_index;
    assign o_tile_last  = r_last;

    `RGBA8TT_ASSERT_NXT(a_wrap, i_clk, i_rst_n, o_pop, r_widx == '0)
    `RGBA8TT_ASSERT_NXT(a_step, i_clk, i_rst_n, load && !o_pop, r_widx == $past(r_widx) + WIDX_W'(1))

endmodule

// File: src/rgba8_texture_tiler_unit.sv
// ----------------------------------------------------------------------------
// RGBA8 texture tiler, top level
// Converts a raster stream of RGBA8 pixels into 4x4 tiles of eight 64-bit words.
// ----------------------------------------------------------------------------
// The block takes one RGBA8 pixel per beat in raster order and, whenever the
// bottom-right pixel of a 4x4 tile arrives, delivers that tile as eight 64-bit
// beats: four alpha/red words for tile rows 0 to 3, then four green/blue words,
// first byte in bits 63 to 56, with o_tile_last on the eighth. Pixels are
// taken one per cycle while the tile queue is not full. On the first three
// lines of each band of four lines nothing is produced and the only limit is
// the input. On the fourth line every group of four pixels queues one tile,
// and the back end sends one word per cycle while i_out_stall is low, so on
// that line the single 64-bit output port sets the pace; the two-entry tile
// queue absorbs short bursts. Lines 0 to 2 of a band are kept four pixels to
// a 128-bit word in one line-store RAM of 3 * MAX_WIDTH / 4 words, which needs
// no clearing pass after reset. A write to either geometry register restarts
// the frame at the top-left pixel; writes are only expected while the block is
// idle. If width or height is zero, not a multiple of four or above its
// maximum, pixels are accepted and discarded.
// ----------------------------------------------------------------------------
module rgba8_texture_tiler_unit #(
    parameter int MAX_WIDTH  = rgba8tt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rgba8tt_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Pixel input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_red,
    input  logic [7:0]                        i_green,
    input  logic [7:0]                        i_blue,
    input  logic [7:0]                        i_alpha,
    // Geometry register write port
    input  logic                              i_cfg_we,
    input  logic [rgba8tt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rgba8tt_pkg::CFG_W-1:0]     i_cfg_data,
    // Tiled word output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [63:0]                       o_tile_word,
    output logic [2:0]                        o_word_index,
    output logic                              o_tile_last
);
    import rgba8tt_pkg::*;

    localparam int STORE_DEPTH = 3 * (MAX_WIDTH / 4);
    localparam int AW          = $clog2(STORE_DEPTH);

    // Line-store connections between the front end and the RAM.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_row          ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    t_row          ram_rdata;

    // Tile queue connections.
    logic               q_push;
    t_tile              q_push_tile;
    logic               q_pop;
    logic [$bits(t_tile)-1:0] q_head;
    t_q_status          q_status;

    rgba8tt_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_alpha     (i_alpha),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_status.full),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_push      (q_push),
        .o_push_tile (q_push_tile)
    );

    rgba8tt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (STORE_DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rgba8tt_queue #(
        .W ($bits(t_tile))
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (q_push_tile),
        .i_pop    (q_pop),
        .o_data   (q_head),
        .o_status (q_status)
    );

    rgba8tt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_status   (q_status),
        .i_q_tile     (t_tile'(q_head)),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_tile_word  (o_tile_word),
        .o_word_index (o_word_index),
        .o_tile_last  (o_tile_last)
    );

    // The front end holds off new pixels only while both queue entries are taken.
    assign o_in_stall = q_status.full;

endmodule
